// File: rtl/mme_pkg.sv
package mme_pkg;

	localparam int BASE_W = 31;
	localparam int EXP_W  = 63;
	localparam int RES_W  = 31;
	localparam int MOD_W  = 31;
	localparam int CNT_W  = $clog2(BASE_W);

	localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_REDUCE = 6'b000010,
		ST_STEP   = 6'b000100,
		ST_MUL    = 6'b001000,
		ST_SQR    = 6'b010000,
		ST_FINISH = 6'b100000
	} mme_state_t;

endpackage

// File: rtl/mme_if.sv
interface mme_req_if import mme_pkg::*;;
	logic               valid;
	logic               ready;
	logic [BASE_W-1:0]  base_value;
	logic [EXP_W-1:0]   exponent;

	modport source (output valid, base_value, exponent, input ready);
	modport sink   (input valid, base_value, exponent, output ready);
endinterface

interface mme_rsp_if import mme_pkg::*;;
	logic              valid;
	logic              ready;
	logic [RES_W-1:0]  residue;

	modport source (output valid, residue, input ready);
	modport sink   (input valid, residue, output ready);
endinterface

interface mme_cfg_if import mme_pkg::*;;
	logic              valid;
	logic              ready;
	logic [MOD_W-1:0]  modulus;

	modport source (output valid, modulus, input ready);
	modport sink   (input valid, modulus, output ready);
endinterface

// File: rtl/modular_exponentiation.sv
// A zero exponent goes straight to the finish state; otherwise the base is first reduced modulo m,
// then the exponent is scanned from its lowest bit, squaring per bit and multiplying per set bit.
// Each modular multiply runs on the shared shift-add-reduce unit.
// Throughput: one request at a time; a new request is taken once the previous result is held.
// Reset: arst_n clears the sequencer and output valid, and sets the modulus to 1000000007.
module modular_exponentiation import mme_pkg::*; #(
	parameter int EXPONENT_BITS = 63,
	parameter int MODULUS_BITS  = 31
) (
	input  logic      clk,
	input  logic      arst_n,
	mme_req_if.sink   request,
	mme_rsp_if.source result,
	mme_cfg_if.sink   cfg
);

	localparam int MW = MODULUS_BITS;
	localparam int EB = EXPONENT_BITS;

	mme_state_t        state_q;
	logic [MW-1:0]     modulus_q;
	logic [MW-1:0]     m_q;
	logic [MW-1:0]     sq_q;
	logic [MW-1:0]     prod_q;
	logic [EB-1:0]     e_q;
	logic              pdone_q;
	logic              out_valid_q;
	logic [RES_W-1:0]  residue_q;

	logic [MW-1:0]     m_eff;
	logic [EB-1:0]     e_in;
	logic              req_acc;
	logic              step_finish;
	logic              step_mul;
	logic              mul_start;
	logic [MW-1:0]     mul_a;
	logic [BASE_W-1:0] mul_b;
	logic [MW-1:0]     mul_m;
	logic              mul_done;
	logic [MW-1:0]     mul_res;

	assign cfg.ready     = 1'b1;
	assign request.ready = (state_q == ST_IDLE);
	assign req_acc       = request.valid && request.ready;
	assign m_eff         = (modulus_q == '0) ? MW'(1) : modulus_q;
	assign e_in          = request.exponent[EB-1:0];

	assign step_finish = (e_q == '0) || (pdone_q && ((e_q >> 1) == '0));
	assign step_mul    = e_q[0] && !pdone_q;

	always_comb begin
		mul_a     = sq_q;
		mul_b     = BASE_W'(sq_q);
		mul_m     = m_q;
		mul_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				mul_a     = MW'(1);
				mul_b     = request.base_value;
				mul_m     = m_eff;
				mul_start = req_acc && (e_in != '0);
			end
			ST_STEP: begin
				if (step_mul) begin
					mul_b = BASE_W'(prod_q);
				end
				mul_start = !step_finish;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	mme_mulmod #(.MW(MW)) u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.m       (mul_m),
		.done    (mul_done),
		.product (mul_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			modulus_q   <= MW'(MOD_RESET);
			pdone_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				modulus_q <= cfg.modulus[MW-1:0];
			end
			if ((state_q == ST_FINISH) && (!out_valid_q || result.ready)) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					pdone_q <= 1'b0;
					if (req_acc) begin
						state_q <= (e_in == '0) ? ST_FINISH : ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					if (mul_done) begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (step_finish) begin
						state_q <= ST_FINISH;
					end else if (step_mul) begin
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_SQR;
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						pdone_q <= 1'b1;
						state_q <= ST_STEP;
					end
				end
				ST_SQR: begin
					if (mul_done) begin
						pdone_q <= 1'b0;
						state_q <= ST_STEP;
					end
				end
				ST_FINISH: begin
					// hold until the output register is free
					if (!out_valid_q || result.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					m_q    <= m_eff;
					e_q    <= e_in;
					prod_q <= MW'(1);
				end
			end
			ST_REDUCE: begin
				if (mul_done) begin
					sq_q <= mul_res;
				end
			end
			ST_MUL: begin
				if (mul_done) begin
					prod_q <= mul_res;
				end
			end
			ST_SQR: begin
				if (mul_done) begin
					sq_q <= mul_res;
					e_q  <= e_q >> 1;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || result.ready) begin
					residue_q <= RES_W'(prod_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign result.valid   = out_valid_q;
	assign result.residue = residue_q;

endmodule

// File: rtl/mme_mulmod.sv
module mme_mulmod import mme_pkg::*; #(
	parameter int MW = 31
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [MW-1:0]     a,
	input  logic [BASE_W-1:0] b,
	input  logic [MW-1:0]     m,
	output logic              done,
	output logic [MW-1:0]     product
);

	logic [MW-1:0]     a_q;
	logic [MW-1:0]     m_q;
	logic [MW:0]       twom_q;
	logic [BASE_W-1:0] b_q;
	logic [MW-1:0]     r_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [MW+1:0]     sum;
	logic [MW+1:0]     sub_one;
	logic [MW+1:0]     sub_two;
	logic [MW-1:0]     r_next;

	// shift in one multiplier bit, then fold back below m
	always_comb begin
		sum     = {1'b0, r_q, 1'b0} + {2'b00, (b_q[BASE_W-1] ? a_q : '0)};
		sub_one = sum - {2'b00, m_q};
		sub_two = sum - {1'b0, twom_q};
		if (sum >= {1'b0, twom_q}) begin
			r_next = sub_two[MW-1:0];
		end else if (sum >= {2'b00, m_q}) begin
			r_next = sub_one[MW-1:0];
		end else begin
			r_next = sum[MW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(BASE_W-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			m_q    <= m;
			twom_q <= {m, 1'b0};
			b_q    <= b;
			r_q    <= '0;
		end else if (busy_q) begin
			r_q <= r_next;
			b_q <= {b_q[BASE_W-2:0], 1'b0};
		end
	end

	assign done    = done_q;
	assign product = r_q;

endmodule

// File: rtl/mme_checker.sv
module mme_checker import mme_pkg::*; #(
	parameter int MODULUS_BITS = 31
) (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [RES_W-1:0] residue,
	input logic             cfg_valid,
	input logic             cfg_ready,
	input logic [MOD_W-1:0] cfg_modulus
);

	logic [MODULUS_BITS-1:0] mod_q;

	// track the modulus as written through the port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MODULUS_BITS'(MOD_RESET);
		end else if (cfg_valid && cfg_ready) begin
			mod_q <= cfg_modulus[MODULUS_BITS-1:0];
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(residue))
		else $error("result dropped or changed while stalled");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while a request is in progress");

	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("result appeared without a request in progress");

	a_residue_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (residue == RES_W'(1)) || (residue < RES_W'(mod_q))
			|| ((mod_q == '0) && (residue == '0)))
		else $error("residue not below modulus");

endmodule

bind modular_exponentiation mme_checker #(.MODULUS_BITS(MODULUS_BITS)) u_mme_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (request.valid),
	.req_ready   (request.ready),
	.rsp_valid   (result.valid),
	.rsp_ready   (result.ready),
	.residue     (result.residue),
	.cfg_valid   (cfg.valid),
	.cfg_ready   (cfg.ready),
	.cfg_modulus (cfg.modulus)
);
